// File: hw/rtl/fcs_pkg.sv
// Package for the chain solver: widths, request codes and register indexes.
// Depends on nothing; the interfaces, the top level and the testbench use it.
package fcs_pkg;
    localparam int JOINTS_DEF = 16;
    localparam int CW = 32;
    localparam logic [1:0] REQ_JOINT = 2'd0;
    localparam logic [1:0] REQ_GROUND = 2'd1;
    localparam logic [1:0] REQ_SOLVE = 2'd2;
    localparam logic [1:0] CFG_SEG = 2'd0;
    localparam logic [1:0] CFG_PASS = 2'd1;
    localparam logic [1:0] CFG_CLR = 2'd2;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [3:0]         joint_index;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] goal_x;
        logic signed [31:0] goal_y;
        logic signed [31:0] goal_z;
        logic signed [31:0] ground_height;
    } t_req;

    typedef struct packed {
        logic [3:0]         out_index;
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic               out_last;
    } t_res;

    typedef struct packed {
        logic [1:0]  index;
        logic [31:0] data;
    } t_cfg;

    // Saturate a 34-bit signed sum to 32 bits.
    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        logic signed [31:0] r;
        if (v > 34'sh0_7FFF_FFFF) r = 32'sh7FFF_FFFF;
        else if (v < -34'sh0_8000_0000) r = 32'sh8000_0000;
        else r = v[31:0];
        return r;
    endfunction
endpackage

// File: hw/rtl/fcs_if.sv
// Valid/ready channel interfaces for requests, results and configuration.
// Depends on fcs_pkg.
interface fcs_req_if;
    logic valid;
    logic ready;
    fcs_pkg::t_req payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface fcs_res_if;
    logic valid;
    logic ready;
    fcs_pkg::t_res payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface fcs_cfg_if;
    logic valid;
    logic ready;
    fcs_pkg::t_cfg payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// File: hw/rtl/fabrik_chain_solver.sv
// Chain solver top level: joint and ground stores, link sequencer, output stage.
// Depends on fcs_pkg and the channel interfaces in fcs_if.
// Write items are taken in S_IDLE. A solve runs pass_count passes, each a backward and a
// forward walk over the links, then reports every joint, with output stalls holding it;
// each link is set by a bit-serial square root and three 63-step serial divides.
// One item at a time. Reset restores the register defaults and zeros the chain.
module fabrik_chain_solver #(
    parameter int JOINTS = fcs_pkg::JOINTS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    fcs_req_if.sink    i_req,
    fcs_cfg_if.sink    i_cfg,
    fcs_res_if.source  o_res
);
    import fcs_pkg::*;
    localparam int JW = (JOINTS > 1) ? $clog2(JOINTS) : 1;

    localparam logic [3:0] S_IDLE = 4'd0, S_LOAD = 4'd1, S_SHIFT = 4'd2,
        S_SQ = 4'd3, S_SQRT = 4'd4, S_DIV = 4'd5, S_WR = 4'd6, S_OUT = 4'd7,
        S_PIN = 4'd8;

    logic signed [31:0] r_jx [JOINTS];
    logic signed [31:0] r_jy [JOINTS];
    logic signed [31:0] r_jz [JOINTS];
    logic signed [31:0] r_gnd [JOINTS];
    logic [30:0] r_seg, r_clr;
    logic [4:0]  r_pass;
    logic [3:0]  r_st;
    t_req        r_req;
    logic [4:0]  r_pcnt;
    logic        r_fwd;
    logic [JW-1:0] r_m, r_f;
    logic signed [32:0] r_d [3];
    logic [32:0] r_a [3];
    logic [63:0] r_sum, r_res;
    logic [5:0]  r_cnt;
    logic [1:0]  r_k;
    logic [62:0] r_num;
    logic [32:0] r_q;
    logic [63:0] r_drem;
    logic [31:0] r_len;
    logic        r_ov;
    t_res        r_out;
    logic [JW:0] r_oi;

    assign i_req.ready = (r_st == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign o_res.valid = r_ov;
    assign o_res.payload = r_out;

    // Store address of a write item.
    logic [JW-1:0] w_widx;
    assign w_widx = JW'(i_req.payload.joint_index);

    // Combinational helpers for the shared unit.
    logic [32:0] w_big;
    logic [63:0] w_dsub;
    logic [63:0] w_dsh;
    logic signed [31:0] w_fv, w_mv, w_nv, w_floor;
    logic signed [32:0] w_off;
    always_comb begin
        w_big = (r_a[0] > r_a[1]) ? r_a[0] : r_a[1];
        if (r_a[2] > w_big) w_big = r_a[2];
        w_dsh = {r_drem[62:0], r_num[62]};
        w_dsub = w_dsh - {32'd0, r_len};
        unique case (r_k)
            2'd0: begin w_fv = r_jx[r_f]; w_mv = r_jx[r_m]; end
            2'd1: begin w_fv = r_jy[r_f]; w_mv = r_jy[r_m]; end
            default: begin w_fv = r_jz[r_f]; w_mv = r_jz[r_m]; end
        endcase
        w_off = r_d[r_k][32] ? -$signed({1'b0, r_q[31:0]}) : $signed({1'b0, r_q[31:0]});
        w_nv = sat32(34'(w_fv) + 34'(w_off));
        w_floor = sat32(34'(r_gnd[r_oi[JW-1:0]]) + 34'({1'b0, r_clr}));
    end

    // Square root bit under test is 4^r_cnt; the trial value adds it to the partial root.
    logic [63:0] w_bit;
    logic [63:0] w_rt;
    assign w_bit = 64'd1 << {r_cnt[4:0], 1'b0};
    assign w_rt = r_res + w_bit;

    logic w_last_link;
    assign w_last_link = r_fwd ? (r_m == JW'(JOINTS - 1)) : (r_m == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg <= 31'd65536; r_pass <= 5'd10; r_clr <= 31'd1311;
            r_st <= S_IDLE; r_ov <= 1'b0;
            for (int i = 0; i < JOINTS; i++) begin
                r_jx[i] <= '0; r_jy[i] <= '0; r_jz[i] <= '0; r_gnd[i] <= '0;
            end
        end else begin
            // Configuration writes.
            if (i_cfg.valid) begin
                unique case (i_cfg.payload.index)
                    CFG_SEG:  r_seg <= i_cfg.payload.data[30:0];
                    CFG_PASS: r_pass <= i_cfg.payload.data[4:0];
                    CFG_CLR:  r_clr <= i_cfg.payload.data[30:0];
                    default: ;
                endcase
            end
            // The output stage refills the register itself while reporting.
            if (r_ov && o_res.ready && r_st != S_OUT) r_ov <= 1'b0;
            unique case (r_st)
                S_IDLE: if (i_req.valid) begin
                    r_req <= i_req.payload;
                    if (i_req.payload.req_type == REQ_JOINT &&
                        32'(i_req.payload.joint_index) < JOINTS) begin
                        r_jx[w_widx] <= i_req.payload.pos_x;
                        r_jy[w_widx] <= i_req.payload.pos_y;
                        r_jz[w_widx] <= i_req.payload.pos_z;
                    end
                    if (i_req.payload.req_type == REQ_GROUND &&
                        32'(i_req.payload.joint_index) < JOINTS)
                        r_gnd[w_widx] <= i_req.payload.ground_height;
                    if (i_req.payload.req_type == REQ_SOLVE) begin
                        r_pcnt <= 5'd0;
                        r_st <= S_PIN;
                    end
                end
                // Start of a pass, or the clamp when all passes are done.
                S_PIN: begin
                    if (r_pcnt == r_pass) begin
                        r_oi <= '0;
                        r_st <= S_OUT;
                    end else begin
                        r_jx[JOINTS-1] <= r_req.goal_x;
                        r_jy[JOINTS-1] <= r_req.goal_y;
                        r_jz[JOINTS-1] <= r_req.goal_z;
                        r_fwd <= 1'b0;
                        r_f <= JW'(JOINTS - 1); r_m <= JW'(JOINTS - 2);
                        r_st <= S_LOAD;
                    end
                end
                // Signed differences of the link, also copied to the magnitude registers.
                S_LOAD: begin
                    r_d[0] <= 33'(r_jx[r_m]) - 33'(r_jx[r_f]);
                    r_d[1] <= 33'(r_jy[r_m]) - 33'(r_jy[r_f]);
                    r_d[2] <= 33'(r_jz[r_m]) - 33'(r_jz[r_f]);
                    r_a[0] <= 33'(r_jx[r_m]) - 33'(r_jx[r_f]);
                    r_a[1] <= 33'(r_jy[r_m]) - 33'(r_jy[r_f]);
                    r_a[2] <= 33'(r_jz[r_m]) - 33'(r_jz[r_f]);
                    r_k <= 2'd0;
                    r_st <= S_SHIFT;
                end
                // Magnitudes, then shift one bit a cycle until below 2^30.
                S_SHIFT: begin
                    if (r_k == 2'd0) begin
                        for (int k = 0; k < 3; k++)
                            r_a[k] <= r_d[k][32] ? 33'(-r_d[k]) : 33'(r_d[k]);
                        r_k <= 2'd1;
                    end else if (w_big >= 33'h0_4000_0000) begin
                        for (int k = 0; k < 3; k++) r_a[k] <= r_a[k] >> 1;
                    end else begin
                        r_sum <= '0; r_k <= 2'd0; r_st <= S_SQ;
                    end
                end
                // Sum of squares, one product per cycle.
                S_SQ: begin
                    r_sum <= r_sum + 64'(r_a[r_k][29:0]) * 64'(r_a[r_k][29:0]);
                    if (r_k == 2'd2) begin
                        r_cnt <= 6'd31; r_res <= '0; r_st <= S_SQRT;
                    end else r_k <= r_k + 2'd1;
                end
                // Bit-serial integer square root, one result bit a cycle.
                S_SQRT: begin
                    if (r_sum >= w_rt) begin
                        r_sum <= r_sum - w_rt;
                        r_res <= (r_res >> 1) + w_bit;
                    end else r_res <= r_res >> 1;
                    if (r_cnt == 6'd0) begin
                        r_k <= 2'd0; r_cnt <= 6'd63; r_st <= S_WR;
                    end else r_cnt <= r_cnt - 6'd1;
                end
                // Set up the divide of a*seg by len for the current axis.
                S_WR: begin
                    r_len <= r_res[31:0];
                    r_num <= 63'(r_a[r_k][29:0]) * 63'(r_seg);
                    r_drem <= '0; r_q <= '0; r_cnt <= 6'd62;
                    r_st <= S_DIV;
                end
                // Restoring divide, one quotient bit a cycle, then write back.
                S_DIV: begin
                    if (r_cnt == 6'd63) begin
                        if (r_len == '0) r_q <= '0;
                        unique case (r_k)
                            2'd0: r_jx[r_m] <= (r_len == '0) ? w_fv : w_nv;
                            2'd1: r_jy[r_m] <= (r_len == '0) ? w_fv : w_nv;
                            // The root is pinned below at the end of the backward walk.
                            default: if (!(w_last_link && !r_fwd))
                                r_jz[r_m] <= (r_len == '0) ? w_fv : w_nv;
                        endcase
                        if (r_k == 2'd2) begin
                            if (w_last_link) begin
                                if (!r_fwd) begin
                                    r_jx[0] <= r_req.pos_x; r_jy[0] <= r_req.pos_y;
                                    r_jz[0] <= r_req.pos_z;
                                    r_fwd <= 1'b1; r_f <= '0; r_m <= JW'(1);
                                    r_st <= S_LOAD;
                                end else begin
                                    r_pcnt <= r_pcnt + 5'd1; r_st <= S_PIN;
                                end
                            end else begin
                                r_f <= r_m;
                                r_m <= r_fwd ? r_m + JW'(1) : r_m - JW'(1);
                                r_st <= S_LOAD;
                            end
                        end else begin
                            r_k <= r_k + 2'd1; r_st <= S_WR;
                        end
                    end else begin
                        r_num <= {r_num[61:0], 1'b0};
                        if (w_dsh >= {32'd0, r_len}) begin
                            r_drem <= w_dsub; r_q <= {r_q[31:0], 1'b1};
                        end else begin
                            r_drem <= w_dsh; r_q <= {r_q[31:0], 1'b0};
                        end
                        r_cnt <= (r_cnt == 6'd0) ? 6'd63 : r_cnt - 6'd1;
                    end
                end
                // Ground clamp and report, one joint per taken item.
                S_OUT: if (!r_ov || o_res.ready) begin
                    r_out.out_index <= 4'(r_oi);
                    r_out.out_x <= r_jx[r_oi[JW-1:0]];
                    r_out.out_y <= r_jy[r_oi[JW-1:0]];
                    if (r_jz[r_oi[JW-1:0]] < w_floor) begin
                        r_jz[r_oi[JW-1:0]] <= w_floor; r_out.out_z <= w_floor;
                    end else r_out.out_z <= r_jz[r_oi[JW-1:0]];
                    r_out.out_last <= (r_oi == (JW+1)'(JOINTS - 1));
                    r_ov <= 1'b1;
                    if (r_oi == (JW+1)'(JOINTS - 1)) r_st <= S_IDLE;
                    else r_oi <= r_oi + (JW+1)'(1);
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule

// File: hw/rtl/fcs_checker.sv
// Port-level checker for the chain solver, bound to the top level.
// Depends on the fabrik_chain_solver top level, to which it is bound.
module fcs_checker (
    input logic   i_clk,
    input logic   i_rst_n,
    input logic   req_ready,
    input logic   res_valid,
    input logic   res_ready,
    input logic   res_last,
    input logic [31:0] res_x
);
    // A held result keeps its data.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_x)) else $error("hold");
    // No request accepted while a result other than the last is on the output.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid && !res_last |-> !req_ready) else $error("busy");
    // A held result keeps its last flag.
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid && !res_ready |=> $stable(res_last)) else $error("last");
endmodule

bind fabrik_chain_solver fcs_checker u_fcs_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .req_ready(i_req.ready),
    .res_valid(o_res.valid), .res_ready(o_res.ready),
    .res_last(o_res.payload.out_last), .res_x(o_res.payload.out_x)
);

// File: tb/sv/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for the FABRIK chain solver: drives write and solve items,
// predicts every reported joint in fixed point and checks each result item.
// Depends on fcs_pkg, the channel interfaces in fcs_if and the fabrik_chain_solver RTL.
module testbench;
    import fcs_pkg::*;

    localparam int NJ = JOINTS_DEF;
    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 20000000;
    localparam int LONG_HOLD = 20000;

    logic i_clk;
    logic i_rst_n;

    fcs_req_if req_if ();
    fcs_cfg_if cfg_if ();
    fcs_res_if res_if ();

    fabrik_chain_solver uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if.sink),
        .i_cfg   (cfg_if.sink),
        .o_res   (res_if.source)
    );

    // Predicted state of the chain and its registers.
    logic signed [31:0] chain [3][NJ];
    logic signed [31:0] ground_h [NJ];
    longint unsigned seg_len;
    longint unsigned passes;
    longint unsigned clearance;

    t_req pending_items [$];
    t_res expected_joints [$];
    int err_count;
    int cyc;
    bit req_taken;
    int burst_left;
    int gap_left;
    int rx_hold;
    bit long_hold_go;

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic logic signed [31:0] clip32(input longint v);
        if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'sh8000_0000;
        return v[31:0];
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned n);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    // Append one item to the driver's queue.
    task automatic queue_item(input t_req it);
        pending_items = {pending_items, it};
    endtask

    // Move joint m to one segment length from joint f, along the line between them.
    task automatic place_link(input int f, input int m);
        longint dv [3];
        longint unsigned av [3];
        longint unsigned big;
        longint unsigned len;
        longint off;
        int sh;
        for (int k = 0; k < 3; k++) begin
            dv[k] = longint'(chain[k][m]) - longint'(chain[k][f]);
            av[k] = (dv[k] < 0) ? longint'(-dv[k]) : dv[k];
        end
        big = av[0];
        if (av[1] > big) big = av[1];
        if (av[2] > big) big = av[2];
        sh = 0;
        while ((big >> sh) >= (64'd1 << 30)) sh++;
        for (int k = 0; k < 3; k++) av[k] >>= sh;
        len = int_sqrt(av[0] * av[0] + av[1] * av[1] + av[2] * av[2]);
        for (int k = 0; k < 3; k++) begin
            off = 0;
            if (len != 0) begin
                off = longint'((av[k] * seg_len) / len);
                if (dv[k] < 0) off = -off;
            end
            chain[k][m] = clip32(longint'(chain[k][f]) + off);
        end
    endtask

    // Apply one accepted item to the predicted chain and queue the joints it reports.
    task automatic predict_item(input t_req it);
        logic signed [31:0] floor_z;
        t_res r;
        case (it.req_type)
            REQ_JOINT: begin
                chain[0][it.joint_index] = it.pos_x;
                chain[1][it.joint_index] = it.pos_y;
                chain[2][it.joint_index] = it.pos_z;
            end
            REQ_GROUND: begin
                ground_h[it.joint_index] = it.ground_height;
            end
            REQ_SOLVE: begin
                for (longint unsigned p = 0; p < passes; p++) begin
                    chain[0][NJ-1] = it.goal_x;
                    chain[1][NJ-1] = it.goal_y;
                    chain[2][NJ-1] = it.goal_z;
                    for (int i = NJ - 2; i >= 0; i--) place_link(i + 1, i);
                    chain[0][0] = it.pos_x;
                    chain[1][0] = it.pos_y;
                    chain[2][0] = it.pos_z;
                    for (int i = 1; i < NJ; i++) place_link(i - 1, i);
                end
                for (int i = 0; i < NJ; i++) begin
                    floor_z = clip32(longint'(ground_h[i]) + longint'(clearance));
                    if (chain[2][i] < floor_z) chain[2][i] = floor_z;
                    r.out_index = i[3:0];
                    r.out_x = chain[0][i];
                    r.out_y = chain[1][i];
                    r.out_z = chain[2][i];
                    r.out_last = (i == NJ - 1);
                    expected_joints = {expected_joints, r};
                end
            end
            default: begin
            end
        endcase
    endtask

    // Cycle counter and timeout.
    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc > CYCLE_LIMIT) begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    // Request acceptance: update the prediction on every accepted item.
    always @(posedge i_clk) begin
        if (i_rst_n && req_if.valid && req_if.ready) begin
            predict_item(req_if.payload);
            req_taken = 1'b1;
        end
    end

    // Request driver: bursts of items with random gaps in between.
    always @(negedge i_clk) begin
        if (i_rst_n && (!req_if.valid || req_taken)) begin
            req_taken = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
                req_if.valid <= 1'b0;
            end else if (pending_items.size() > 0) begin
                req_if.payload <= pending_items.pop_front();
                req_if.valid <= 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 12);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
                end
            end else begin
                req_if.valid <= 1'b0;
            end
        end
    end

    // Result receiver: stalls on a pattern chosen from the cycle counter, plus one long hold.
    always @(negedge i_clk) begin
        if (rx_hold > 0) begin
            rx_hold--;
            res_if.ready <= 1'b0;
        end else if (long_hold_go) begin
            long_hold_go = 1'b0;
            rx_hold = LONG_HOLD;
            res_if.ready <= 1'b0;
        end else begin
            case ((cyc >> 8) % 3)
                0: res_if.ready <= 1'b1;
                1: res_if.ready <= $urandom_range(0, 1);
                default: res_if.ready <= (cyc % 5 == 0);
            endcase
        end
    end

    // Result checker: compare each result item with the oldest expected joint.
    always @(posedge i_clk) begin
        t_res exp_r;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (expected_joints.size() == 0) begin
                $error("unexpected result item, index %0d", res_if.payload.out_index);
                err_count++;
            end else begin
                exp_r = expected_joints.pop_front();
                if (res_if.payload.out_index !== exp_r.out_index) begin
                    $error("out_index: expected %0d, got %0d", exp_r.out_index,
                           res_if.payload.out_index);
                    err_count++;
                end
                if (res_if.payload.out_x !== exp_r.out_x) begin
                    $error("out_x: expected %0d, got %0d", exp_r.out_x, res_if.payload.out_x);
                    err_count++;
                end
                if (res_if.payload.out_y !== exp_r.out_y) begin
                    $error("out_y: expected %0d, got %0d", exp_r.out_y, res_if.payload.out_y);
                    err_count++;
                end
                if (res_if.payload.out_z !== exp_r.out_z) begin
                    $error("out_z: expected %0d, got %0d", exp_r.out_z, res_if.payload.out_z);
                    err_count++;
                end
                if (res_if.payload.out_last !== exp_r.out_last) begin
                    $error("out_last: expected %0d, got %0d", exp_r.out_last,
                           res_if.payload.out_last);
                    err_count++;
                end
            end
        end
    end

    // Coordinates weighted towards the extremes and towards realistic small values.
    function automatic logic signed [31:0] pick_coord();
        case ($urandom_range(0, 9))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return 32'sh0;
            3, 4: return $urandom;
            default: return $signed($urandom_range(0, 32'h0014_0000)) - 32'sh000A_0000;
        endcase
    endfunction

    function automatic t_req make_item(input logic [1:0] kind, input logic [3:0] idx);
        t_req it;
        it.req_type = kind;
        it.joint_index = idx;
        it.pos_x = pick_coord();
        it.pos_y = pick_coord();
        it.pos_z = pick_coord();
        it.goal_x = pick_coord();
        it.goal_y = pick_coord();
        it.goal_z = pick_coord();
        it.ground_height = pick_coord();
        return it;
    endfunction

    // Mostly joint and ground loads, mixed at random with solves and some unused requests.
    task automatic add_random_items(input int n);
        int r;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(0, 9);
            if (r == 0) queue_item(make_item(REQ_UNUSED, 4'($urandom)));
            else if (r <= 4) queue_item(make_item(REQ_JOINT, 4'($urandom)));
            else if (r <= 6) queue_item(make_item(REQ_GROUND, 4'($urandom)));
            else queue_item(make_item(REQ_SOLVE, 4'($urandom)));
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
        @(negedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.payload <= '{index: idx, data: data};
        do @(posedge i_clk); while (!cfg_if.ready);
        case (idx)
            CFG_SEG: seg_len = data[30:0];
            CFG_PASS: passes = data[4:0];
            CFG_CLR: clearance = data[30:0];
            default: begin
            end
        endcase
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    // Wait until every item is sent and every expected joint has arrived.
    task automatic wait_drained();
        do @(negedge i_clk);
        while (pending_items.size() != 0 || req_if.valid || expected_joints.size() != 0);
        repeat (50) @(posedge i_clk);
    endtask

    task automatic set_regs(input logic [31:0] seg, input logic [31:0] pc,
                            input logic [31:0] clr);
        write_reg(CFG_SEG, seg);
        write_reg(CFG_PASS, pc);
        write_reg(CFG_CLR, clr);
    endtask

    // Stimulus and end of run.
    initial begin
        t_req it;
        i_rst_n = 1'b0;
        req_if.valid = 1'b0;
        req_if.payload = '0;
        cfg_if.valid = 1'b0;
        cfg_if.payload = '0;
        res_if.ready = 1'b0;
        err_count = 0;
        cyc = 0;
        req_taken = 1'b0;
        burst_left = 0;
        gap_left = 0;
        rx_hold = 0;
        long_hold_go = 1'b0;
        seg_len = 65536;
        passes = 10;
        clearance = 1311;
        for (int i = 0; i < NJ; i++) begin
            for (int k = 0; k < 3; k++) chain[k][i] = '0;
            ground_h[i] = '0;
        end
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: solve from the zeroed chain, where every direction has zero length.
        it = '0;
        it.req_type = REQ_SOLVE;
        queue_item(it);
        // Unused request type gives nothing.
        it = make_item(REQ_UNUSED, 4'd3);
        queue_item(it);
        // Extreme joint and ground writes at both ends of the chain.
        it = '0;
        it.req_type = REQ_JOINT;
        it.joint_index = 4'd0;
        it.pos_x = 32'sh7FFF_FFFF;
        it.pos_y = 32'sh8000_0000;
        it.pos_z = 32'sh7FFF_FFFF;
        queue_item(it);
        it.joint_index = 4'd15;
        it.pos_x = 32'sh8000_0000;
        it.pos_y = 32'sh7FFF_FFFF;
        it.pos_z = 32'sh8000_0000;
        queue_item(it);
        it = '0;
        it.req_type = REQ_GROUND;
        it.joint_index = 4'd15;
        it.ground_height = 32'sh7FFF_FFFF;
        queue_item(it);
        it.joint_index = 4'd0;
        it.ground_height = 32'sh8000_0000;
        queue_item(it);
        it.joint_index = 4'd7;
        it.ground_height = 32'sh0005_0000;
        queue_item(it);
        // Solve with root and goal at opposite corners, saturating coordinates.
        it = '0;
        it.req_type = REQ_SOLVE;
        it.pos_x = 32'sh8000_0000;
        it.pos_y = 32'sh8000_0000;
        it.pos_z = 32'sh8000_0000;
        it.goal_x = 32'sh7FFF_FFFF;
        it.goal_y = 32'sh7FFF_FFFF;
        it.goal_z = 32'sh7FFF_FFFF;
        it.joint_index = 4'd15;
        it.ground_height = 32'sh7FFF_FFFF;
        queue_item(it);
        // Goal equal to the root, near the origin.
        it = '0;
        it.req_type = REQ_SOLVE;
        it.pos_z = 32'sh0001_0000;
        it.goal_z = 32'sh0001_0000;
        queue_item(it);
        for (int k = 0; k < 8; k++) queue_item(make_item(REQ_JOINT, 4'($urandom)));
        queue_item(make_item(REQ_SOLVE, 4'd0));
        wait_drained();

        // Zero link length, single pass, no clearance.
        set_regs(32'h8000_0000, 32'd1, 32'h0);
        add_random_items(10);
        wait_drained();

        // Largest link length and clearance.
        set_regs(32'h7FFF_FFFF, 32'd2, 32'h7FFF_FFFF);
        add_random_items(10);
        wait_drained();

        // Largest pass count that the register holds, one solve only.
        set_regs(32'h0001_0000, 32'hFFFF_FFFF, 32'd1311);
        queue_item(make_item(REQ_SOLVE, 4'd0));
        wait_drained();

        // No passes: only the ground clamp applies.
        set_regs($urandom, 32'd0, $urandom_range(0, 32'h0004_0000));
        add_random_items(10);
        wait_drained();

        // Sixteen passes.
        set_regs(32'h0001_0000, 32'd16, 32'd655);
        queue_item(make_item(REQ_SOLVE, 4'd0));
        queue_item(make_item(REQ_SOLVE, 4'd0));
        wait_drained();

        // Random settings with short solves; the first phase holds the results back a while.
        for (int ph = 0; ph < 4; ph++) begin
            set_regs(($urandom_range(0, 1) == 0) ? $urandom : $urandom_range(1, 32'h0008_0000),
                     $urandom_range(1, 3), $urandom_range(0, 32'h0002_0000));
            if (ph == 0) long_hold_go = 1'b1;
            add_random_items(25);
            wait_drained();
        end

        repeat (200) @(posedge i_clk);
        if (err_count == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end
endmodule

// File: sim.f
hw/rtl/fcs_pkg.sv
hw/rtl/fcs_if.sv
hw/rtl/fabrik_chain_solver.sv
hw/rtl/fcs_checker.sv
tb/sv/testbench.sv
